>>> rtl/core/bsd_pkg.sv
// Shared types and constants of the BMP stream decoder.
package bsd_pkg;

  // Largest accepted image width or height.
  localparam int unsigned MAX_DIM = 4096;
  // Width of a stored dimension: it can hold MAX_DIM + 1, the clamp value.
  localparam int unsigned DIM_W   = 13;
  // Width of column and row counters and coordinates.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned INDEX_W = 24;

  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(MAX_DIM + 1);

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_INFO_SIZE = 2'd1,
    ERR_DEPTH     = 2'd2,
    ERR_DIMS      = 2'd3
  } error_code_e;

  // One input word: a file byte and the start marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  // One result word.
  typedef struct packed {
    result_kind_e       result_kind;
    error_code_e        error_code;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] dest_row;
    logic [INDEX_W-1:0] pixel_index;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic               last_pixel;
  } out_item_t;

  // Result of decoding one word, handed to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

>>> rtl/core/bmp_stream_decoder_top.sv
// Top level of the BMP stream decoder: input register, decode stage and result register.
//
// The decoder takes a BMP file one byte per input word and returns at most one result
// word per byte: a header-accepted word carrying the image size, a header-rejected word
// carrying an error code, or one RGBA pixel with its column, its bottom-up flipped row
// and its destination index. A word with start_of_file set restarts parsing at file byte
// zero; after reset the first bytes are parsed as the start of a file. Only 24- and
// 32-bit uncompressed pixels with 40-, 108- or 124-byte info headers are handled, and
// after a rejection or the last pixel further bytes are dropped until the next start.
// The block sustains one byte per clock cycle as long as the output is not stalled:
// every byte passes through an input register and then one combinational decode pass,
// whose longest path is the 12 by 13 bit multiply that forms the pixel index, into the
// result register, from which its result is presented. Bytes that cause no result
// (header bytes, the bytes of a pixel before its last one, and row padding) take the
// same path.
// in_ready_o follows out_ready_i combinationally through both stages, so a stall at the
// output stops the input in the same cycle once the registers are full.
module bmp_stream_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsd_pkg::in_item_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsd_pkg::out_item_t out_word_o
);

  logic              in_valid_q, in_valid_d;
  bsd_pkg::in_item_t in_word_q;
  logic              advance;
  logic              can_load;
  bsd_pkg::result_t  result;

  // The registered byte is decoded and moves on whenever the result register can
  // take whatever it produces, including nothing.
  assign advance    = in_valid_q && can_load;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // The byte itself needs no reset; it is only used while in_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Parser state lives in the decode stage and advances once per consumed byte.
  bsd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_word_q),
    .result_o  (result)
  );

  bsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/core/bsd_decode.sv
// Parser state and the single-pass decode of one file byte.
module bsd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  bsd_pkg::in_item_t item_i,
  output bsd_pkg::result_t  result_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_IDLE   = 2'd2
  } phase_e;

  localparam logic [7:0]  POS_INFO_END   = 8'd17;
  localparam logic [7:0]  POS_WIDTH_END  = 8'd21;
  localparam logic [7:0]  POS_HEIGHT_END = 8'd25;
  localparam logic [7:0]  POS_BPP_END    = 8'd29;
  localparam logic [7:0]  POS_MAX        = 8'd255;
  localparam logic [7:0]  FILE_HDR_LAST  = 8'd13;
  localparam logic [31:0] INFO_LEN_40    = 32'd40;
  localparam logic [31:0] INFO_LEN_108   = 32'd108;
  localparam logic [31:0] INFO_LEN_124   = 32'd124;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;
  localparam logic [2:0]  BYTES_24       = 3'd3;
  localparam logic [2:0]  BYTES_32       = 3'd4;
  localparam logic [1:0]  ALPHA_SLOT     = 2'd3;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;

  localparam int unsigned DW = bsd_pkg::DIM_W;
  localparam int unsigned CW = bsd_pkg::COORD_W;

  // A negative or oversized dimension is stored as one above the limit.
  function automatic logic [DW-1:0] clamp_dim(input logic [31:0] v);
    logic [DW-1:0] r;
    if (v[31] || (v > 32'(bsd_pkg::MAX_DIM))) begin
      r = bsd_pkg::DIM_CLAMP;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  phase_e        phase_q, phase_d;
  logic [7:0]    pos_q, pos_d;
  logic [31:0]   shift_q, shift_d;
  logic [6:0]    info_q, info_d;
  logic [DW-1:0] width_q, width_d;
  logic [DW-1:0] height_q, height_d;
  logic [2:0]    bpp_q, bpp_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [1:0]    bip_q, bip_d;
  logic [23:0]   gather_q, gather_d;
  logic [1:0]    pad_q, pad_d;

  phase_e        cur_phase;
  logic [7:0]    cur_pos;
  logic [23:0]   gather_now;
  logic [7:0]    alpha;
  logic [2:0]    bip_next;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] dest_row_full;
  logic [CW-1:0] dest_row;
  logic [24:0]   row_base;
  logic [24:0]   index_full;
  logic [15:0]   bpp_field;

  always_comb begin
    // The start marker restarts parsing with this byte as file byte 0.
    cur_phase = item_i.start_of_file ? PH_HEADER : phase_q;
    cur_pos   = item_i.start_of_file ? 8'd0 : pos_q;

    phase_d  = cur_phase;
    pos_d    = cur_pos;
    shift_d  = shift_q;
    info_d   = info_q;
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    col_d    = col_q;
    row_d    = row_q;
    bip_d    = bip_q;
    gather_d = gather_q;
    pad_d    = pad_q;

    result_o = '0;

    // Pixel datapath, used only in the pixel phase.
    gather_now = gather_q;
    alpha      = ALPHA_OPAQUE;
    case (bip_q)
      2'd0:    gather_now[7:0]   = item_i.data_byte;
      2'd1:    gather_now[15:8]  = item_i.data_byte;
      2'd2:    gather_now[23:16] = item_i.data_byte;
      default: alpha             = item_i.data_byte;
    endcase
    bip_next      = {1'b0, bip_q} + 3'd1;
    col_inc       = {1'b0, col_q} + DW'(1);
    row_inc       = {1'b0, row_q} + DW'(1);
    dest_row_full = height_q - DW'(1) - {1'b0, row_q};
    dest_row      = dest_row_full[CW-1:0];
    row_base      = 25'(dest_row) * 25'(width_q);
    index_full    = row_base + 25'(col_q);
    bpp_field     = 16'd0;

    unique case (cur_phase)
      PH_HEADER: begin
        shift_d = {item_i.data_byte, shift_q[31:8]};
        bpp_field = shift_d[31:16];
        if (cur_pos != POS_MAX) begin
          pos_d = cur_pos + 8'd1;
        end
        if (cur_pos == POS_INFO_END) begin
          if ((shift_d != INFO_LEN_40) && (shift_d != INFO_LEN_108) &&
              (shift_d != INFO_LEN_124)) begin
            result_o.valid                 = 1'b1;
            result_o.item.result_kind      = bsd_pkg::KIND_REJECT;
            result_o.item.error_code       = bsd_pkg::ERR_INFO_SIZE;
            phase_d                        = PH_IDLE;
          end else begin
            info_d = shift_d[6:0];
          end
        end else if (cur_pos == POS_WIDTH_END) begin
          width_d = clamp_dim(shift_d);
        end else if (cur_pos == POS_HEIGHT_END) begin
          height_d = clamp_dim(shift_d);
        end else if (cur_pos == POS_BPP_END) begin
          if ((bpp_field != BPP_24) && (bpp_field != BPP_32)) begin
            result_o.valid            = 1'b1;
            result_o.item.result_kind = bsd_pkg::KIND_REJECT;
            result_o.item.error_code  = bsd_pkg::ERR_DEPTH;
            phase_d                   = PH_IDLE;
          end else begin
            bpp_d = (bpp_field == BPP_24) ? BYTES_24 : BYTES_32;
            if ((width_q > bsd_pkg::DIM_LIMIT) || (height_q > bsd_pkg::DIM_LIMIT)) begin
              result_o.valid            = 1'b1;
              result_o.item.result_kind = bsd_pkg::KIND_REJECT;
              result_o.item.error_code  = bsd_pkg::ERR_DIMS;
              phase_d                   = PH_IDLE;
            end
          end
        end else if ((cur_pos > POS_BPP_END) &&
                     (cur_pos == (FILE_HDR_LAST + {1'b0, info_q}))) begin
          // Last byte of the info header: report the size and start pixels.
          result_o.valid             = 1'b1;
          result_o.item.result_kind  = bsd_pkg::KIND_ACCEPT;
          result_o.item.image_width  = width_q;
          result_o.item.image_height = height_q;
          col_d    = '0;
          row_d    = '0;
          bip_d    = '0;
          gather_d = '0;
          pad_d    = '0;
          phase_d  = ((width_q == '0) || (height_q == '0)) ? PH_IDLE : PH_PIXEL;
        end
      end

      PH_PIXEL: begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 2'd1;
        end else if (bip_next < bpp_q) begin
          bip_d    = bip_next[1:0];
          gather_d = gather_now;
        end else begin
          result_o.valid             = 1'b1;
          result_o.item.result_kind  = bsd_pkg::KIND_PIXEL;
          result_o.item.red          = gather_now[23:16];
          result_o.item.green        = gather_now[15:8];
          result_o.item.blue         = gather_now[7:0];
          result_o.item.alpha        = (bip_q == ALPHA_SLOT) ? alpha : ALPHA_OPAQUE;
          result_o.item.column       = col_q;
          result_o.item.dest_row     = dest_row;
          result_o.item.pixel_index  = index_full[bsd_pkg::INDEX_W-1:0];
          result_o.item.image_width  = width_q;
          result_o.item.image_height = height_q;
          result_o.item.last_pixel   = (row_inc == height_q) && (col_inc == width_q);
          bip_d    = '0;
          gather_d = '0;
          if (col_inc >= width_q) begin
            col_d = '0;
            row_d = row_inc[CW-1:0];
            if (row_inc >= height_q) begin
              phase_d = PH_IDLE;
            end else begin
              // Row length in bytes is 3*width or 4*width; 3*width pads by width mod 4.
              pad_d = (bpp_q == BYTES_32) ? 2'd0 : width_q[1:0];
            end
          end else begin
            col_d = col_inc[CW-1:0];
          end
        end
      end

      PH_IDLE: begin
      end

      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      shift_q  <= '0;
      info_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      bpp_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      gather_q <= '0;
      pad_q    <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      info_q   <= info_d;
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      gather_q <= gather_d;
      pad_q    <= pad_d;
    end
  end

endmodule

>>> rtl/core/bsd_out_reg.sv
// Result register that holds a decoded word until the consumer takes it.
module bsd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bsd_pkg::result_t   result_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsd_pkg::out_item_t out_word_o
);

  logic               valid_q, valid_d;
  bsd_pkg::out_item_t word_q;

  // The register may take a new word when it is empty or being emptied.
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = result_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      word_q <= result_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> rtl/core/bsd_checker.sv
// Port-level checks of the BMP stream decoder and their binding to the top level.
module bsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bsd_pkg::out_item_t out_word_o
);

  // A result word held back by the consumer stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A rejection carries an error code and no image size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind == bsd_pkg::KIND_REJECT) |->
      (out_word_o.error_code != bsd_pkg::ERR_NONE) &&
      (out_word_o.image_width == '0) && (out_word_o.image_height == '0))
    else $error("malformed rejection word");

  // An accepted header reports a size within the limit and no error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind == bsd_pkg::KIND_ACCEPT) |->
      (out_word_o.error_code == bsd_pkg::ERR_NONE) &&
      (out_word_o.image_width <= bsd_pkg::DIM_LIMIT) &&
      (out_word_o.image_height <= bsd_pkg::DIM_LIMIT))
    else $error("malformed accept word");

  // Every pixel lies inside the image it belongs to.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind == bsd_pkg::KIND_PIXEL) |->
      ({1'b0, out_word_o.column} < out_word_o.image_width) &&
      ({1'b0, out_word_o.dest_row} < out_word_o.image_height))
    else $error("pixel outside the image");

  // The final pixel is the last column of the source top row, which lands in row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last_pixel |->
      (out_word_o.result_kind == bsd_pkg::KIND_PIXEL) &&
      (out_word_o.dest_row == '0) &&
      ({1'b0, out_word_o.column} == (out_word_o.image_width - 13'd1)))
    else $error("last pixel flag on the wrong pixel");

endmodule

bind bmp_stream_decoder_top bsd_checker u_bsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
